// ===== sv/fixed_to_decimal_ascii_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point to decimal text converter
// Each macro states one clocked implication, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef FIXED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define FIXED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define F2D_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define F2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/f2d_pkg.sv =====
// ----------------------------------------------------------------------------
// f2d_pkg
// Constants, types and the control program of the decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package f2d_pkg;

	// Number format.
	localparam int VALUE_W     = 48;
	localparam int FRAC_BITS   = 16;
	localparam int INT_DIGITS  = 10;
	localparam int INT_W       = VALUE_W - FRAC_BITS;
	// The integer part plus room for the rounding carry.
	localparam int IP_W        = INT_W + 1;

	// Fraction rendering: three digits, scale of one thousand.
	localparam int FRAC_DIGITS = 3;
	localparam int FRAC_SCALE  = 1000;
	localparam int FR_W        = 10;
	localparam int PROD_W      = FRAC_BITS + FR_W;

	// Packed BCD widths.
	localparam int BCD_W       = INT_DIGITS * 4;
	localparam int FBCD_W      = FRAC_DIGITS * 4;

	// The integer limit fits in four bits per decimal digit.
	localparam int LIM_W       = INT_DIGITS * 4;
	localparam int CMP_W       = (IP_W > LIM_W) ? IP_W : LIM_W;

	// Step counter covers the longest loop of the program.
	localparam int CNT_MAX     = (IP_W > INT_DIGITS) ? IP_W : INT_DIGITS;
	localparam int CNT_W       = $clog2(CNT_MAX);

	// ASCII codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// Largest integer part that fits in INT_DIGITS digits.
	function automatic logic [CMP_W-1:0] int_limit();
		logic [CMP_W-1:0] p;
		p = CMP_W'(1);
		for (int i = 0; i < INT_DIGITS; i++) begin
			p = p * CMP_W'(10);
		end
		return p - CMP_W'(1);
	endfunction

	localparam logic [CMP_W-1:0] INT_LIMIT = int_limit();

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_MAG,
		OP_MUL,
		OP_CARRY,
		OP_SAT,
		OP_DABBLE,
		OP_SIGN,
		OP_SKIP,
		OP_INT,
		OP_DOT,
		OP_FRAC
	} op_t;

	// Branch conditions.
	typedef enum logic [1:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_CNT_NZ,
		CND_SKIP
	} cond_t;

	// Program addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] PC_MAG    = 4'd1;
	localparam logic [PC_W-1:0] PC_MUL    = 4'd2;
	localparam logic [PC_W-1:0] PC_CARRY  = 4'd3;
	localparam logic [PC_W-1:0] PC_SAT    = 4'd4;
	localparam logic [PC_W-1:0] PC_DABBLE = 4'd5;
	localparam logic [PC_W-1:0] PC_SIGN   = 4'd6;
	localparam logic [PC_W-1:0] PC_SKIP   = 4'd7;
	localparam logic [PC_W-1:0] PC_INT    = 4'd8;
	localparam logic [PC_W-1:0] PC_DOT    = 4'd9;
	localparam logic [PC_W-1:0] PC_FRAC   = 4'd10;
	localparam logic [PC_W-1:0] PC_DONE   = 4'd11;

	// One control word.
	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// Status returned by the datapath to the sequencer.
	typedef struct packed {
		logic hold;
		logic cnt_nz;
		logic skip_zero;
	} status_t;

	// One character offered to the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] code;
		logic       last;
	} emit_t;

	// Control program.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			PC_WAIT:   w = '{OP_WAIT_IN, CND_NEXT,   PC_WAIT};
			PC_MAG:    w = '{OP_MAG,     CND_NEXT,   PC_WAIT};
			PC_MUL:    w = '{OP_MUL,     CND_NEXT,   PC_WAIT};
			PC_CARRY:  w = '{OP_CARRY,   CND_NEXT,   PC_WAIT};
			PC_SAT:    w = '{OP_SAT,     CND_NEXT,   PC_WAIT};
			PC_DABBLE: w = '{OP_DABBLE,  CND_CNT_NZ, PC_DABBLE};
			PC_SIGN:   w = '{OP_SIGN,    CND_NEXT,   PC_WAIT};
			PC_SKIP:   w = '{OP_SKIP,    CND_SKIP,   PC_SKIP};
			PC_INT:    w = '{OP_INT,     CND_CNT_NZ, PC_INT};
			PC_DOT:    w = '{OP_DOT,     CND_NEXT,   PC_WAIT};
			PC_FRAC:   w = '{OP_FRAC,    CND_CNT_NZ, PC_FRAC};
			PC_DONE:   w = '{OP_NOP,     CND_ALWAYS, PC_WAIT};
			default:   w = '{OP_NOP,     CND_ALWAYS, PC_WAIT};
		endcase
		return w;
	endfunction

	// Add three to every BCD digit of five or more, ahead of a shift.
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		for (int i = 0; i < INT_DIGITS; i++) begin
			r[i*4 +: 4] = (b[i*4 +: 4] >= 4'd5) ? b[i*4 +: 4] + 4'd3 : b[i*4 +: 4];
		end
		return r;
	endfunction

	function automatic logic [FBCD_W-1:0] fbcd_adjust(input logic [FBCD_W-1:0] b);
		logic [FBCD_W-1:0] r;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			r[i*4 +: 4] = (b[i*4 +: 4] >= 4'd5) ? b[i*4 +: 4] + 4'd3 : b[i*4 +: 4];
		end
		return r;
	endfunction

endpackage

// ===== sv/f2d_seq.sv =====
// ----------------------------------------------------------------------------
// f2d_seq
// Program counter and control store; one control word per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module f2d_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  f2d_pkg::status_t   status,
	output f2d_pkg::uword_t    uword
);

	logic [f2d_pkg::PC_W-1:0] pc_q;
	logic [f2d_pkg::PC_W-1:0] pc_next;

	// Fetch the current control word.
	assign uword = f2d_pkg::ucode(pc_q);

	// Branch selection; a held step keeps its address.
	always_comb begin
		pc_next = pc_q + 1'b1;
		if (status.hold) begin
			pc_next = pc_q;
		end else begin
			unique case (uword.cond)
				f2d_pkg::CND_NEXT:   pc_next = pc_q + 1'b1;
				f2d_pkg::CND_ALWAYS: pc_next = uword.target;
				f2d_pkg::CND_CNT_NZ: pc_next = status.cnt_nz ? uword.target : pc_q + 1'b1;
				f2d_pkg::CND_SKIP:   pc_next = status.skip_zero ? uword.target : pc_q + 1'b1;
				default:             pc_next = f2d_pkg::PC_WAIT;
			endcase
		end
	end

	// Program counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= f2d_pkg::PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== sv/f2d_dp.sv =====
// ----------------------------------------------------------------------------
// f2d_dp
// Datapath: magnitude, rounded fraction, shift-add-three BCD conversion and
// character selection, all steered by the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module f2d_dp (
	input  logic                             clk,
	input  f2d_pkg::uword_t                  uword,
	input  logic                             value_valid,
	input  logic [f2d_pkg::VALUE_W-1:0]      value,
	input  logic                             out_free,
	output logic                             value_stall,
	output f2d_pkg::emit_t                   emit,
	output f2d_pkg::status_t                 status
);

	localparam logic [f2d_pkg::FR_W-1:0] SCALE_V = f2d_pkg::FR_W'(f2d_pkg::FRAC_SCALE);
	localparam logic [f2d_pkg::FR_W-1:0] FRAC_MAX_V = f2d_pkg::FR_W'(f2d_pkg::FRAC_SCALE - 1);
	localparam logic [f2d_pkg::PROD_W-1:0] ROUND_HALF =
		f2d_pkg::PROD_W'(1) << (f2d_pkg::FRAC_BITS - 1);
	localparam logic [f2d_pkg::VALUE_W-1:0] MAX_POS =
		{1'b0, {(f2d_pkg::VALUE_W - 1){1'b1}}};

	logic [f2d_pkg::VALUE_W-1:0] value_q;
	logic [f2d_pkg::VALUE_W-1:0] mag_q;
	logic                        neg_q;
	logic [f2d_pkg::IP_W-1:0]    ip_q;
	logic [f2d_pkg::FR_W-1:0]    frac_q;
	logic [f2d_pkg::IP_W-1:0]    sh_q;
	logic [f2d_pkg::IP_W-1:0]    fsh_q;
	logic [f2d_pkg::BCD_W-1:0]   bcd_q;
	logic [f2d_pkg::FBCD_W-1:0]  fbcd_q;
	logic [f2d_pkg::CNT_W-1:0]   cnt_q;

	logic [f2d_pkg::VALUE_W-1:0] neg_v;
	logic [f2d_pkg::PROD_W-1:0]  prod;
	logic [f2d_pkg::PROD_W-1:0]  rounded;
	logic [f2d_pkg::BCD_W-1:0]   bcd_adj;
	logic [f2d_pkg::FBCD_W-1:0]  fbcd_adj;
	logic                        advance;
	logic                        over_limit;
	logic [3:0]                  int_digit;
	logic [3:0]                  frac_digit;

	assign neg_v      = -value_q;
	assign prod       = f2d_pkg::PROD_W'(mag_q[f2d_pkg::FRAC_BITS-1:0])
	                  * f2d_pkg::PROD_W'(SCALE_V);
	assign rounded    = prod + ROUND_HALF;
	assign over_limit = f2d_pkg::CMP_W'(ip_q) > f2d_pkg::INT_LIMIT;
	assign int_digit  = bcd_q[f2d_pkg::BCD_W-1 -: 4];
	assign frac_digit = fbcd_q[f2d_pkg::FBCD_W-1 -: 4];

	// Digits of five or more get three added ahead of the next shift.
	assign bcd_adj    = f2d_pkg::bcd_adjust(bcd_q);
	assign fbcd_adj   = f2d_pkg::fbcd_adjust(fbcd_q);

	// Status, handshake and character offer for the current step.
	always_comb begin
		value_stall      = 1'b1;
		emit             = '{1'b0, f2d_pkg::CH_ZERO, 1'b0};
		status.cnt_nz    = cnt_q != '0;
		status.skip_zero = (int_digit == 4'd0) && (cnt_q != '0);
		status.hold      = 1'b0;
		unique case (uword.op)
			f2d_pkg::OP_WAIT_IN: begin
				value_stall = 1'b0;
				status.hold = !value_valid;
			end
			f2d_pkg::OP_SIGN: begin
				emit        = '{neg_q, f2d_pkg::CH_MINUS, 1'b0};
				status.hold = neg_q && !out_free;
			end
			f2d_pkg::OP_INT: begin
				emit        = '{1'b1, f2d_pkg::CH_ZERO + {4'h0, int_digit}, 1'b0};
				status.hold = !out_free;
			end
			f2d_pkg::OP_DOT: begin
				emit        = '{1'b1, f2d_pkg::CH_DOT, 1'b0};
				status.hold = !out_free;
			end
			f2d_pkg::OP_FRAC: begin
				emit        = '{1'b1, f2d_pkg::CH_ZERO + {4'h0, frac_digit}, cnt_q == '0};
				status.hold = !out_free;
			end
			default: begin
				status.hold = 1'b0;
			end
		endcase
	end

	assign advance = !status.hold;

	// Datapath registers, updated by the operation of each step.
	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (uword.op)
				f2d_pkg::OP_WAIT_IN: begin
					value_q <= value;
				end
				f2d_pkg::OP_MAG: begin
					// Negate negative inputs; the most negative one saturates.
					neg_q <= value_q[f2d_pkg::VALUE_W-1];
					if (value_q[f2d_pkg::VALUE_W-1]) begin
						mag_q <= neg_v[f2d_pkg::VALUE_W-1] ? MAX_POS : neg_v;
					end else begin
						mag_q <= value_q;
					end
				end
				f2d_pkg::OP_MUL: begin
					frac_q <= rounded[f2d_pkg::PROD_W-1:f2d_pkg::FRAC_BITS];
					ip_q   <= {1'b0, mag_q[f2d_pkg::VALUE_W-1:f2d_pkg::FRAC_BITS]};
				end
				f2d_pkg::OP_CARRY: begin
					// A fraction that rounds up to one thousand carries.
					if (frac_q >= SCALE_V) begin
						frac_q <= frac_q - SCALE_V;
						ip_q   <= ip_q + 1'b1;
					end
				end
				f2d_pkg::OP_SAT: begin
					if (over_limit) begin
						sh_q  <= f2d_pkg::INT_LIMIT[f2d_pkg::IP_W-1:0];
						fsh_q <= f2d_pkg::IP_W'(FRAC_MAX_V);
					end else begin
						sh_q  <= ip_q;
						fsh_q <= f2d_pkg::IP_W'(frac_q);
					end
					bcd_q  <= '0;
					fbcd_q <= '0;
					cnt_q  <= f2d_pkg::CNT_W'(f2d_pkg::IP_W - 1);
				end
				f2d_pkg::OP_DABBLE: begin
					// One binary bit enters both BCD registers per step.
					bcd_q  <= {bcd_adj[f2d_pkg::BCD_W-2:0], sh_q[f2d_pkg::IP_W-1]};
					fbcd_q <= {fbcd_adj[f2d_pkg::FBCD_W-2:0], fsh_q[f2d_pkg::IP_W-1]};
					sh_q   <= {sh_q[f2d_pkg::IP_W-2:0], 1'b0};
					fsh_q  <= {fsh_q[f2d_pkg::IP_W-2:0], 1'b0};
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				f2d_pkg::OP_SIGN: begin
					cnt_q <= f2d_pkg::CNT_W'(f2d_pkg::INT_DIGITS - 1);
				end
				f2d_pkg::OP_SKIP: begin
					// Drop leading zeros, keeping at least the ones digit.
					if (status.skip_zero) begin
						bcd_q <= {bcd_q[f2d_pkg::BCD_W-5:0], 4'h0};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				f2d_pkg::OP_INT: begin
					bcd_q <= {bcd_q[f2d_pkg::BCD_W-5:0], 4'h0};
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				f2d_pkg::OP_DOT: begin
					cnt_q <= f2d_pkg::CNT_W'(f2d_pkg::FRAC_DIGITS - 1);
				end
				f2d_pkg::OP_FRAC: begin
					fbcd_q <= {fbcd_q[f2d_pkg::FBCD_W-5:0], 4'h0};
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					neg_q <= neg_q;
				end
			endcase
		end
	end

endmodule

// ===== sv/fixed_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top
// Signed fixed-point number in, its decimal text out, one character per word.
// ----------------------------------------------------------------------------
// Each accepted value (48-bit two's complement, 16 fraction bits) comes out
// as an optional '-', the integer part without leading zeros, '.', and three
// fraction digits rounded half up; last marks the final digit. The block
// converts one number at a time and takes the next value after the last
// character of the previous one has left the sequencer. Between one
// acceptance and the next the control program runs four setup steps, 33
// shift-add-three steps (one per integer bit plus the carry bit), eleven
// steps that drop leading zeros and send the integer digits, the sign and
// point steps, three fraction steps, the return step and the input step.
// Output stalls hold the character steps. The output register lets one
// character wait while the sequencer prepares the next.
`timescale 1ns / 1ps

module fixed_to_decimal_ascii_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              value_valid,
	output logic                              value_stall,
	input  logic signed [f2d_pkg::VALUE_W-1:0] value,
	output logic                              char_valid,
	input  logic                              char_stall,
	output logic [7:0]                        char_code,
	output logic                              last
);

	f2d_pkg::uword_t  uword;
	f2d_pkg::status_t status;
	f2d_pkg::emit_t   emit;
	logic             out_free;
	logic             char_valid_q;
	logic [7:0]       char_code_q;
	logic             last_q;

	f2d_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uword  (uword)
	);

	f2d_dp u_dp (
		.clk         (clk),
		.uword       (uword),
		.value_valid (value_valid),
		.value       (value),
		.out_free    (out_free),
		.value_stall (value_stall),
		.emit        (emit),
		.status      (status)
	);

	// The output register can take a word when empty or being drained.
	assign out_free = !char_valid_q || !char_stall;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (emit.valid && out_free) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit.valid && out_free) begin
			char_code_q <= emit.code;
			last_q      <= emit.last;
		end
	end

	assign char_valid = char_valid_q;
	assign char_code  = char_code_q;
	assign last       = last_q;

endmodule

// ===== sv/f2d_chk.sv =====
// ----------------------------------------------------------------------------
// f2d_chk
// Port-level checks of the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_to_decimal_ascii_top_defines.svh"

module f2d_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              value_valid,
	input logic                              value_stall,
	input logic                              char_valid,
	input logic                              char_stall,
	input logic [7:0]                        char_code,
	input logic                              last
);

	// The final character of a number is always a fraction digit.
	`F2D_ASSERT_SAME(a_last_is_digit, char_valid && last, (char_code >= 8'h30) && (char_code <= 8'h39), "last flag on a character that is not a digit")

	// While a number's text is unfinished, no new value is taken.
	`F2D_ASSERT_SAME(a_busy_stalls_input, char_valid && !last, value_stall, "input ready in the middle of a number's text")

	// An accepted value starts a conversion, so input stalls next cycle.
	`F2D_ASSERT_NEXT(a_accept_then_stall, value_valid && !value_stall, value_stall, "input ready right after an accepted value")

	// A stalled character word holds.
	`F2D_ASSERT_NEXT(a_out_hold, char_valid && char_stall, char_valid && $stable(char_code) && $stable(last), "stalled output word changed")

endmodule

bind fixed_to_decimal_ascii_top f2d_chk u_f2d_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_valid),
	.value_stall (value_stall),
	.char_valid  (char_valid),
	.char_stall  (char_stall),
	.char_code   (char_code),
	.last        (last)
);

// ===== verif/fixed_to_decimal_ascii_top_test.sv =====
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top_test
// Drives signed fixed-point numbers into the converter and checks every
// character word of the decimal text against a predictor. A short directed
// list covers the rounding, carry, sign and saturation corners. A random mix
// follows under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_to_decimal_ascii_top_test;

	localparam int unsigned NUM_RANDOM = 330;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam logic [f2d_pkg::VALUE_W-1:0] MAG_MAX =
		{1'b0, {(f2d_pkg::VALUE_W-1){1'b1}}};

	// One number waiting to be sent, with the idle pattern it runs under.
	typedef struct {
		logic [f2d_pkg::VALUE_W-1:0] num;
		int unsigned                 mix;
	} number_item_t;

	// One expected character word.
	typedef struct {
		logic [7:0] code;
		logic       last;
	} char_word_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                value_valid = 1'b0;
	logic                                value_stall;
	logic signed [f2d_pkg::VALUE_W-1:0]  value = '0;
	logic                                char_valid;
	logic                                char_stall = 1'b0;
	logic [7:0]                          char_code;
	logic                                last;

	number_item_t pending_numbers [$];
	char_word_t   expected_text [$];
	logic         value_taken = 1'b0;
	int unsigned  stall_mix = 0;
	int unsigned  send_gap_pct [3] = '{7, 62, 0};
	int unsigned  recv_stall_pct [3] = '{62, 7, 0};
	int unsigned  mismatches = 0;
	int unsigned  numbers_sent = 0;
	int unsigned  chars_checked = 0;
	int unsigned  carries_seen = 0;

	fixed_to_decimal_ascii_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.last        (last)
	);

	always #4 clk = ~clk;

	// Append one character word to the expected text.
	function automatic void push_char(input logic [7:0] code, input logic fin);
		char_word_t w;
		w.code = code;
		w.last = fin;
		expected_text.push_back(w);
	endfunction

	// Expected decimal text of one number: sign, integer digits, point and
	// three rounded fraction digits.
	function automatic void render_decimal(input logic [f2d_pkg::VALUE_W-1:0] raw);
		logic                        neg;
		logic [f2d_pkg::VALUE_W-1:0] mag;
		longint unsigned             whole;
		longint unsigned             fbits;
		longint unsigned             milli;
		longint unsigned             cap;
		logic [3:0]                  digits [f2d_pkg::INT_DIGITS];
		int                          ndig;
		int                          i;
		neg = raw[f2d_pkg::VALUE_W-1];
		mag = neg ? -raw : raw;
		// The most negative number has no positive twin.
		if (mag > MAG_MAX) begin
			mag = MAG_MAX;
		end
		whole = mag >> f2d_pkg::FRAC_BITS;
		fbits = mag & ((64'd1 << f2d_pkg::FRAC_BITS) - 64'd1);
		milli = (fbits * 64'd1000 + (64'd1 << (f2d_pkg::FRAC_BITS - 1))) >> f2d_pkg::FRAC_BITS;
		// Rounding up to a full thousand moves into the integer part.
		if (milli >= 64'd1000) begin
			milli = milli - 64'd1000;
			whole = whole + 64'd1;
			carries_seen++;
		end
		cap = 64'd1;
		for (i = 0; i < f2d_pkg::INT_DIGITS; i++) begin
			cap = cap * 64'd10;
		end
		cap = cap - 64'd1;
		if (whole > cap) begin
			whole = cap;
			milli = 64'd999;
		end
		if (neg) begin
			push_char(f2d_pkg::CH_MINUS, 1'b0);
		end
		if (whole == 64'd0) begin
			push_char(f2d_pkg::CH_ZERO, 1'b0);
		end else begin
			ndig = 0;
			while (whole > 64'd0 && ndig < f2d_pkg::INT_DIGITS) begin
				digits[ndig] = 4'(whole % 64'd10);
				whole = whole / 64'd10;
				ndig++;
			end
			for (i = ndig; i > 0; i--) begin
				push_char(f2d_pkg::CH_ZERO + 8'(digits[i-1]), 1'b0);
			end
		end
		push_char(f2d_pkg::CH_DOT, 1'b0);
		push_char(f2d_pkg::CH_ZERO + 8'(milli / 64'd100), 1'b0);
		push_char(f2d_pkg::CH_ZERO + 8'((milli / 64'd10) % 64'd10), 1'b0);
		push_char(f2d_pkg::CH_ZERO + 8'(milli % 64'd10), 1'b1);
	endfunction

	// Build a fixed-point number from its integer part, fraction bits and sign.
	function automatic logic [f2d_pkg::VALUE_W-1:0] fixed_of(
		input logic [f2d_pkg::INT_W-1:0] whole,
		input logic [f2d_pkg::FRAC_BITS-1:0] fbits, input logic neg);
		logic [f2d_pkg::VALUE_W-1:0] v;
		v = {whole, fbits};
		return neg ? -v : v;
	endfunction

	function automatic void queue_number(input logic [f2d_pkg::VALUE_W-1:0] v,
		input int unsigned mix);
		number_item_t it;
		it.num = v;
		it.mix = mix;
		pending_numbers.push_back(it);
	endfunction

	// Sender: offer the next number at the falling edge once the current word
	// is taken, with random gaps set by the idle pattern of that number.
	always @(negedge clk) begin
		number_item_t nxt;
		if (arst_n) begin
			if (!value_valid || value_taken) begin
				if (pending_numbers.size() != 0 &&
					$urandom_range(99) >= send_gap_pct[pending_numbers[0].mix]) begin
					nxt = pending_numbers.pop_front();
					value <= nxt.num;
					value_valid <= 1'b1;
					stall_mix <= nxt.mix;
				end else begin
					value_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall on the character channel.
	always @(negedge clk) begin
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else begin
			char_stall <= ($urandom_range(99) < recv_stall_pct[stall_mix]);
		end
	end

	// Monitor: check each accepted character word, then predict the text of
	// each accepted number.
	always @(posedge clk) begin
		char_word_t want;
		if (!arst_n) begin
			value_taken <= 1'b0;
		end else begin
			value_taken <= value_valid && !value_stall;
			if (char_valid && !char_stall) begin
				if (expected_text.size() == 0) begin
					$error("char_code: expected none, actual 0x%02h", char_code);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					chars_checked++;
					if (char_code !== want.code) begin
						$error("char_code: expected 0x%02h, actual 0x%02h", want.code, char_code);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						mismatches++;
					end
				end
			end
			if (value_valid && !value_stall) begin
				render_decimal(value);
				numbers_sent++;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [f2d_pkg::INT_W-1:0]   decade;
		logic [f2d_pkg::VALUE_W-1:0] v;
		logic                        neg;
		int unsigned                 pick;
		int unsigned                 k;
		int unsigned                 mix;
		int unsigned                 j;
		int unsigned                 total;

		// Directed corners: zero, tiny values on both sides of rounding,
		// exact half, carry into the integer part, extremes of the range.
		queue_number('0, 0);
		queue_number(fixed_of(0, 16'h0001, 1'b0), 0);
		queue_number(fixed_of(0, 16'h0001, 1'b1), 0);
		queue_number(fixed_of(0, 16'd32, 1'b1), 0);
		queue_number(fixed_of(0, 16'd33, 1'b0), 0);
		queue_number(fixed_of(0, 16'h0083, 1'b0), 0);
		queue_number(fixed_of(0, 16'h8000, 1'b0), 0);
		queue_number(fixed_of(0, 16'h1000, 1'b0), 0);
		queue_number(fixed_of(0, 16'h0FFF, 1'b0), 0);
		queue_number(fixed_of(0, 16'hFFFF, 1'b0), 0);
		queue_number(fixed_of(0, 16'hFFFF, 1'b1), 0);
		queue_number(fixed_of(9, 16'hFFFF, 1'b0), 0);
		queue_number(fixed_of(999999999, 16'hFFFF, 1'b0), 0);
		queue_number(fixed_of(1, 16'h0000, 1'b0), 0);
		queue_number(fixed_of(1, 16'h0000, 1'b1), 0);
		queue_number(fixed_of(123, 16'h74BC, 1'b0), 0);
		queue_number(fixed_of(1000000000, 16'h0000, 1'b1), 0);
		queue_number(fixed_of(32'h7FFF_FFFF, 16'h0000, 1'b0), 0);
		queue_number(48'h7FFF_FFFF_FFFF, 0);
		queue_number(48'h8000_0000_0000, 0);
		queue_number(48'h8000_0000_0001, 0);
		queue_number(48'hFFFF_FFFF_FFFF, 0);

		// Random mix: full-range words, small magnitudes, fractions next to
		// the carry, exact halves, powers of ten and tiny values that round to zero or to 0.001.
		total = pending_numbers.size() + NUM_RANDOM;
		for (j = 0; j < NUM_RANDOM; j++) begin
			mix = (pending_numbers.size() * 3) / total;
			pick = $urandom_range(9);
			neg = 1'($urandom_range(1));
			k = $urandom_range(9);
			decade = 1;
			repeat (k) decade = decade * 10;
			case (pick)
				0, 1, 2, 3: v = {16'($urandom), 32'($urandom)};
				4, 5: v = fixed_of($urandom_range(999), 16'($urandom), neg);
				6: v = fixed_of(decade - 1, 16'hFFFF - 16'($urandom_range(15)), neg);
				7: v = fixed_of($urandom_range(99),
					16'(4096 + 8192 * $urandom_range(7) + $urandom_range(2) - 1), neg);
				8: v = fixed_of(decade - f2d_pkg::INT_W'($urandom_range(1)),
					16'($urandom), neg);
				default: v = fixed_of(0, 16'($urandom_range(63)), neg);
			endcase
			queue_number(v, mix);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || value_valid) @(posedge clk);
		while (expected_text.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d numbers converted, %0d characters compared, %0d rounding carries",
			numbers_sent, chars_checked, carries_seen);
		$display("idle patterns: receiver-heavy stalls, sender-heavy gaps, then none");
		if (mismatches == 0) begin
			$display("fixed_to_decimal_ascii_top: match");
		end else begin
			$display("fixed_to_decimal_ascii_top: mismatch");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4_000_000;
		$display("fixed_to_decimal_ascii_top: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/f2d_pkg.sv
sv/f2d_seq.sv
sv/f2d_dp.sv
sv/fixed_to_decimal_ascii_top.sv
sv/f2d_chk.sv
verif/fixed_to_decimal_ascii_top_test.sv
